@@ hdl/lqrb_pkg.sv @@
// shared types, widths and constants of the balance state-feedback block
// no dependencies; imported by every module under hdl

package lqrb_pkg;

  localparam int STATE_COUNT = 4;
  localparam int VAL_W       = 32;
  localparam int GAIN_W      = 16;
  localparam int DT_W        = 16;
  localparam int ERR_W       = VAL_W + 1;
  localparam int PROD_W      = GAIN_W + ERR_W;
  localparam int ACC_W       = 52;
  localparam int BOUND_W     = 31;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_JOINT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_WHEEL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_KI      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_BOUND  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_BND  = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BND  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 8'd7;

  localparam logic [BOUND_W-1:0] INT_BOUND_RESET   = 31'd65536;
  localparam logic [BOUND_W-1:0] JOINT_BOUND_RESET = 31'd655360;
  localparam logic [BOUND_W-1:0] WHEEL_BOUND_RESET = 31'd327680;

  localparam logic signed [ERR_W-1:0] ANGLE_WINDOW_RAW = 33'sd13107;
  localparam logic signed [VAL_W-1:0] ANGLE_UNSAFE_RAW = 32'sd34078;
  localparam logic signed [VAL_W-1:0] RATE_UNSAFE_RAW  = 32'sd524288;
  localparam logic signed [VAL_W-1:0] SPEED_UNSAFE_RAW = 32'sd3276800;

  typedef struct packed {
    logic signed [VAL_W-1:0] tilt_angle;
    logic signed [VAL_W-1:0] tilt_rate;
    logic signed [VAL_W-1:0] wheel_angle;
    logic signed [VAL_W-1:0] wheel_speed;
    logic [DT_W-1:0]         time_step;
    logic                    clear_integral;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] joint_torque;
    logic signed [VAL_W-1:0] wheel_torque;
    logic                    unsafe;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic enabled;
    logic load_err;
    logic load_prod;
    logic load_int;
    logic load_ki;
    logic load_acc;
  } ctrl_t;

endpackage

@@ hdl/lqrb_lane.sv @@
// one state lane: error against reference and both gain products
// depends on lqrb_pkg

module lqrb_lane (
  input  logic                                  clk,
  input  lqrb_pkg::ctrl_t                       ctrl,
  input  logic signed [lqrb_pkg::VAL_W-1:0]     meas,
  input  logic signed [lqrb_pkg::VAL_W-1:0]     ref_val,
  input  logic signed [lqrb_pkg::GAIN_W-1:0]    gain_joint,
  input  logic signed [lqrb_pkg::GAIN_W-1:0]    gain_wheel,
  output logic signed [lqrb_pkg::ERR_W-1:0]     err,
  output logic signed [lqrb_pkg::PROD_W-1:0]    prod_joint,
  output logic signed [lqrb_pkg::PROD_W-1:0]    prod_wheel
);
  import lqrb_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load_err) begin
      err <= ERR_W'(meas) - ERR_W'(ref_val);
    end
    if (ctrl.load_prod) begin
      prod_joint <= PROD_W'(gain_joint) * PROD_W'(err);
      prod_wheel <= PROD_W'(gain_wheel) * PROD_W'(err);
    end
  end

endmodule

@@ hdl/lqrb_merge.sv @@
// merging stage: angle integral, lane sums, feedforward, rounding and saturation
// depends on lqrb_pkg; takes the products of the lqrb_lane instances

module lqrb_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lqrb_pkg::ctrl_t                       ctrl,
  input  logic signed [lqrb_pkg::ERR_W-1:0]     err0,
  input  logic signed [lqrb_pkg::PROD_W-1:0]    prod_joint [lqrb_pkg::STATE_COUNT],
  input  logic signed [lqrb_pkg::PROD_W-1:0]    prod_wheel [lqrb_pkg::STATE_COUNT],
  input  logic [lqrb_pkg::DT_W-1:0]             dt,
  input  logic signed [lqrb_pkg::VAL_W-1:0]     ref_angle,
  input  logic signed [lqrb_pkg::VAL_W-1:0]     ref_wheel,
  input  logic signed [lqrb_pkg::GAIN_W-1:0]    ff_joint,
  input  logic signed [lqrb_pkg::GAIN_W-1:0]    ff_wheel,
  input  logic signed [lqrb_pkg::GAIN_W-1:0]    ki,
  input  logic [lqrb_pkg::BOUND_W-1:0]          int_bound,
  input  logic [lqrb_pkg::BOUND_W-1:0]          joint_bound,
  input  logic [lqrb_pkg::BOUND_W-1:0]          wheel_bound,
  output logic signed [lqrb_pkg::VAL_W-1:0]     joint_torque,
  output logic signed [lqrb_pkg::VAL_W-1:0]     wheel_torque
);
  import lqrb_pkg::*;

  localparam int INC_W  = ERR_W + DT_W + 1;
  localparam int INCR_W = INC_W - DT_W;
  localparam int SUM_W  = VAL_W + 3;
  localparam int FF_W   = GAIN_W + VAL_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int RND_W  = ACC_W - 8;

  logic signed [VAL_W-1:0]  integral;
  logic signed [INC_W-1:0]  inc_prod;
  logic                     in_window;
  logic signed [FF_W-1:0]   ff_joint_prod;
  logic signed [FF_W-1:0]   ff_wheel_prod;
  logic signed [PAIR_W-1:0] pj01, pj23, pw01, pw23;
  logic signed [FF_W-1:0]   ki_prod;
  logic signed [ACC_W-1:0]  joint_acc;
  logic signed [ACC_W-1:0]  wheel_part;
  logic signed [ACC_W-1:0]  wheel_acc;

  logic signed [INC_W-1:0]  inc_half;
  logic signed [INCR_W-1:0] inc_round;
  logic signed [SUM_W-1:0]  int_sum;
  logic signed [SUM_W-1:0]  int_lim;
  logic signed [VAL_W-1:0]  integral_next;

  function automatic logic signed [VAL_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc,
    input logic [BOUND_W-1:0]      bound
  );
    logic [ACC_W-1:0]        sum;
    logic signed [RND_W-1:0] r;
    logic signed [RND_W-1:0] b;
    sum = acc + {{(ACC_W-8){1'b0}}, 8'h80};
    r   = sum[ACC_W-1:8];
    b   = RND_W'(bound);
    if (r > b) begin
      r = b;
    end else if (r < -b) begin
      r = -b;
    end
    return r[VAL_W-1:0];
  endfunction

  always_comb begin
    inc_half  = inc_prod + INC_W'(signed'(33'sd32768));
    inc_round = inc_half[INC_W-1:DT_W];
    int_sum   = SUM_W'(integral) + (in_window ? SUM_W'(inc_round) : '0);
    int_lim   = SUM_W'(int_bound);
    if (int_sum > int_lim) begin
      integral_next = int_lim[VAL_W-1:0];
    end else if (int_sum < -int_lim) begin
      integral_next = VAL_W'(-int_lim);
    end else begin
      integral_next = int_sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else if (ctrl.clear) begin
      integral <= '0;
    end else if (ctrl.load_int && ctrl.enabled) begin
      integral <= integral_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      inc_prod      <= INC_W'(err0) * INC_W'(signed'({1'b0, dt}));
      in_window     <= (err0 <= ANGLE_WINDOW_RAW) && (err0 >= -ANGLE_WINDOW_RAW);
      ff_joint_prod <= FF_W'(ff_joint) * FF_W'(ref_angle);
      ff_wheel_prod <= FF_W'(ff_wheel) * FF_W'(ref_wheel);
    end
    if (ctrl.load_int) begin
      pj01 <= PAIR_W'(prod_joint[0]) + PAIR_W'(prod_joint[1]);
      pj23 <= PAIR_W'(prod_joint[2]) + PAIR_W'(prod_joint[3]);
      pw01 <= PAIR_W'(prod_wheel[0]) + PAIR_W'(prod_wheel[1]);
      pw23 <= PAIR_W'(prod_wheel[2]) + PAIR_W'(prod_wheel[3]);
    end
    if (ctrl.load_ki) begin
      ki_prod    <= FF_W'(ki) * FF_W'(integral);
      joint_acc  <= ACC_W'(ff_joint_prod) - ACC_W'(pj01) - ACC_W'(pj23);
      wheel_part <= ACC_W'(ff_wheel_prod) - ACC_W'(pw01) - ACC_W'(pw23);
    end
    if (ctrl.load_acc) begin
      wheel_acc <= wheel_part - ACC_W'(ki_prod);
    end
  end

  assign joint_torque = ctrl.enabled ? round_sat(joint_acc, joint_bound) : '0;
  assign wheel_torque = ctrl.enabled ? round_sat(wheel_acc, wheel_bound) : '0;

  assert property (@(posedge clk) disable iff (rst)
    ctrl.clear |=> integral == '0)
    else $error("integral not cleared");

  assert property (@(posedge clk) disable iff (rst)
    ctrl.load_int && ctrl.enabled && !ctrl.clear |=>
      (SUM_W'(integral) <= $signed(SUM_W'($past(int_bound)))) &&
      (SUM_W'(integral) >= -$signed(SUM_W'($past(int_bound)))))
    else $error("integral outside its bound");

  assert property (@(posedge clk) disable iff (rst)
    ctrl.load_int && !ctrl.enabled && !ctrl.clear |=> $stable(integral))
    else $error("integral moved while disabled");

endmodule

@@ hdl/lqr_balance_state_feedback.sv @@
// balance state-feedback controller: a request is not taken until the sequencer has
// stepped through error, lane multiply, integral, ki multiply, wheel sum and saturation
// and loaded the previous result into the output register
// a new request is taken while the previous result still waits in the output register
// sync active-high reset clears control state and integral, presets config registers
// depends on lqrb_pkg, lqrb_lane and lqrb_merge

module lqr_balance_state_feedback (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  lqrb_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output lqrb_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lqrb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lqrb_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import lqrb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERR  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_INT  = 3'd3;
  localparam logic [2:0] ST_KI   = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]           state, state_next;
  logic [63:0]          gain_row_joint;
  logic [63:0]          gain_row_wheel;
  logic [47:0]          ff_ki_gains;
  logic [63:0]          reference_pair;
  logic [BOUND_W-1:0]   integral_bound;
  logic [BOUND_W-1:0]   joint_torque_bound;
  logic [BOUND_W-1:0]   wheel_torque_bound;
  logic                 controller_enabled;

  in_item_t             item;
  logic                 unsafe;
  logic                 in_fire, out_fire, cfg_fire, out_load;
  ctrl_t                ctrl;

  logic signed [VAL_W-1:0]  meas [STATE_COUNT];
  logic signed [VAL_W-1:0]  refs [STATE_COUNT];
  logic signed [ERR_W-1:0]  err  [STATE_COUNT];
  logic signed [PROD_W-1:0] prod_joint [STATE_COUNT];
  logic signed [PROD_W-1:0] prod_wheel [STATE_COUNT];
  logic signed [VAL_W-1:0]  joint_torque, wheel_torque;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_row_joint     <= '0;
      gain_row_wheel     <= '0;
      ff_ki_gains        <= '0;
      reference_pair     <= '0;
      integral_bound     <= INT_BOUND_RESET;
      joint_torque_bound <= JOINT_BOUND_RESET;
      wheel_torque_bound <= WHEEL_BOUND_RESET;
      controller_enabled <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_GAIN_JOINT: gain_row_joint     <= cfg_data;
        REG_GAIN_WHEEL: gain_row_wheel     <= cfg_data;
        REG_FF_KI:      ff_ki_gains        <= cfg_data[47:0];
        REG_REFERENCE:  reference_pair     <= cfg_data;
        REG_INT_BOUND:  integral_bound     <= cfg_data[BOUND_W-1:0];
        REG_JOINT_BND:  joint_torque_bound <= cfg_data[BOUND_W-1:0];
        REG_WHEEL_BND:  wheel_torque_bound <= cfg_data[BOUND_W-1:0];
        REG_ENABLE:     controller_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_ERR;
      ST_ERR:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_INT;
      ST_INT:  state_next = ST_KI;
      ST_KI:   state_next = ST_ACC;
      ST_ACC:  state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item   <= in_data;
      unsafe <= (in_data.tilt_angle > ANGLE_UNSAFE_RAW) ||
                (in_data.tilt_angle < -ANGLE_UNSAFE_RAW) ||
                (in_data.tilt_rate > RATE_UNSAFE_RAW) ||
                (in_data.tilt_rate < -RATE_UNSAFE_RAW) ||
                (in_data.wheel_speed > SPEED_UNSAFE_RAW) ||
                (in_data.wheel_speed < -SPEED_UNSAFE_RAW);
    end
    if (out_load) begin
      out_data.joint_torque <= joint_torque;
      out_data.wheel_torque <= wheel_torque;
      out_data.unsafe       <= unsafe;
    end
  end

  always_comb begin
    ctrl.clear     = (in_fire && in_data.clear_integral) ||
                     (cfg_fire && (cfg_index == REG_ENABLE));
    ctrl.enabled   = controller_enabled;
    ctrl.load_err  = (state == ST_ERR);
    ctrl.load_prod = (state == ST_MUL);
    ctrl.load_int  = (state == ST_INT);
    ctrl.load_ki   = (state == ST_KI);
    ctrl.load_acc  = (state == ST_ACC);
  end

  assign meas[0] = item.tilt_angle;
  assign meas[1] = item.tilt_rate;
  assign meas[2] = item.wheel_angle;
  assign meas[3] = item.wheel_speed;
  assign refs[0] = reference_pair[31:0];
  assign refs[1] = '0;
  assign refs[2] = '0;
  assign refs[3] = reference_pair[63:32];

  for (genvar i = 0; i < STATE_COUNT; i++) begin : g_lane
    lqrb_lane u_lane (
      .clk        (clk),
      .ctrl       (ctrl),
      .meas       (meas[i]),
      .ref_val    (refs[i]),
      .gain_joint (gain_row_joint[GAIN_W*i +: GAIN_W]),
      .gain_wheel (gain_row_wheel[GAIN_W*i +: GAIN_W]),
      .err        (err[i]),
      .prod_joint (prod_joint[i]),
      .prod_wheel (prod_wheel[i])
    );
  end

  lqrb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .err0         (err[0]),
    .prod_joint   (prod_joint),
    .prod_wheel   (prod_wheel),
    .dt           (item.time_step),
    .ref_angle    (refs[0]),
    .ref_wheel    (refs[3]),
    .ff_joint     (ff_ki_gains[15:0]),
    .ff_wheel     (ff_ki_gains[31:16]),
    .ki           (ff_ki_gains[47:32]),
    .int_bound    (integral_bound),
    .joint_bound  (joint_torque_bound),
    .wheel_bound  (wheel_torque_bound),
    .joint_torque (joint_torque),
    .wheel_torque (wheel_torque)
  );

  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_ERR)
    else $error("request accepted but sequencer did not start");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) && !out_valid |=> out_valid && (state == ST_IDLE))
    else $error("finished result not loaded");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && (state == ST_OUT) |=> state == ST_OUT)
    else $error("result overwritten while waiting");

  assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset did not clear control state");

endmodule
